// ----- rtl/rof2d_pkg.sv -----
package rof2d_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;
  localparam int MINN_W = 13;
  localparam int RAD_W = 48;
  localparam int INDEX_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int DRAIN_CYCLES = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAST_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_SQUARED = CFG_IDX_W'(1);

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_PRIME = 6'b000010,
    ST_SWEEP = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_CLOSE = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic prime;
    logic eval;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic scan;
    logic keep;
    logic close;
  } emit_ctrl_t;

  typedef struct packed {
    logic take;
    logic done;
  } emit_stat_t;

endpackage

// ----- rtl/rof2d_cell.sv -----
module rof2d_cell #(
  parameter int COORD_BITS = rof2d_pkg::COORD_BITS_DEF,
  parameter int CNT_W = 7,
  parameter int INDEX = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rof2d_pkg::cell_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]             loaded,
  input  logic [rof2d_pkg::RAD_W-1:0]  radius_squared,
  input  logic signed [COORD_BITS-1:0] load_x,
  input  logic signed [COORD_BITS-1:0] load_y,
  input  logic signed [COORD_BITS-1:0] next_x,
  input  logic signed [COORD_BITS-1:0] next_y,
  input  logic [CNT_W-1:0]             next_cnt,
  input  logic signed [COORD_BITS-1:0] ring_in_x,
  input  logic signed [COORD_BITS-1:0] ring_in_y,
  input  logic                         ring_in_v,
  output logic signed [COORD_BITS-1:0] res_x,
  output logic signed [COORD_BITS-1:0] res_y,
  output logic [CNT_W-1:0]             count,
  output logic signed [COORD_BITS-1:0] ring_x,
  output logic signed [COORD_BITS-1:0] ring_y,
  output logic                         ring_v
);

  localparam int SQ_W = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > rof2d_pkg::RAD_W) ? SUM_W : rof2d_pkg::RAD_W;

  logic signed [COORD_BITS:0] ddx;
  logic signed [COORD_BITS:0] ddy;
  logic [COORD_BITS:0] adx;
  logic [COORD_BITS:0] ady;
  logic [COORD_BITS-1:0] d1x;
  logic [COORD_BITS-1:0] d1y;
  logic v1;
  logic [SQ_W-1:0] sq2x;
  logic [SQ_W-1:0] sq2y;
  logic v2;
  logic [SUM_W-1:0] dsum;
  logic near;

  always_comb begin
    ddx = {res_x[COORD_BITS-1], res_x} - {ring_x[COORD_BITS-1], ring_x};
    ddy = {res_y[COORD_BITS-1], res_y} - {ring_y[COORD_BITS-1], ring_y};
    adx = ddx[COORD_BITS] ? (-ddx) : ddx;
    ady = ddy[COORD_BITS] ? (-ddy) : ddy;
    dsum = {1'b0, sq2x} + {1'b0, sq2y};
    near = CMP_W'(dsum) < CMP_W'(radius_squared);
  end

  // resident point, written on load, shifted toward cell zero on emit
  always_ff @(posedge clk) begin
    if (ctrl.load && loaded == CNT_W'(INDEX)) begin
      res_x <= load_x;
      res_y <= load_y;
    end else if (ctrl.shift) begin
      res_x <= next_x;
      res_y <= next_y;
    end
  end

  // travelling copy on the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_v <= 1'b0;
    end else if (ctrl.prime) begin
      ring_v <= CNT_W'(INDEX) < loaded;
    end else if (ctrl.eval) begin
      ring_v <= ring_in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prime) begin
      ring_x <= res_x;
      ring_y <= res_y;
    end else if (ctrl.eval) begin
      ring_x <= ring_in_x;
      ring_y <= ring_in_y;
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctrl.eval && ring_v;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    d1x <= adx[COORD_BITS-1:0];
    d1y <= ady[COORD_BITS-1:0];
    sq2x <= d1x * d1x;
    sq2y <= d1y * d1y;
  end

  always_ff @(posedge clk) begin
    if (ctrl.prime) begin
      count <= '0;
    end else if (ctrl.shift) begin
      count <= next_cnt;
    end else if (v2 && near) begin
      count <= count + CNT_W'(1);
    end
  end

endmodule

// ----- rtl/rof2d_emit.sv -----
module rof2d_emit #(
  parameter int COORD_BITS = rof2d_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rof2d_pkg::emit_ctrl_t               ctl,
  input  logic [rof2d_pkg::INDEX_W-1:0]       cand_index,
  input  logic signed [COORD_BITS-1:0]        cand_x,
  input  logic signed [COORD_BITS-1:0]        cand_y,
  input  logic                                ovf,
  output rof2d_pkg::emit_stat_t               stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rof2d_pkg::INDEX_W-1:0]       point_index,
  output logic signed [COORD_BITS-1:0]        kept_x,
  output logic signed [COORD_BITS-1:0]        kept_y,
  output logic                                run_end,
  output logic                                nothing_kept,
  output logic                                overflowed
);

  logic pend_v;
  logic [rof2d_pkg::INDEX_W-1:0] pend_idx;
  logic signed [COORD_BITS-1:0] pend_x;
  logic signed [COORD_BITS-1:0] pend_y;
  logic slot_free;
  logic push_mid;
  logic push_end;

  // a kept point waits in pend until the next one shows whether it is the final one
  always_comb begin
    slot_free = !out_valid || out_ready;
    push_mid = ctl.scan && ctl.keep && pend_v && slot_free;
    push_end = ctl.close && slot_free;
    stat.take = ctl.scan && (!(ctl.keep && pend_v) || slot_free);
    stat.done = push_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (push_end) begin
      pend_v <= 1'b0;
    end else if (stat.take && ctl.keep) begin
      pend_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.take && ctl.keep) begin
      pend_idx <= cand_index;
      pend_x <= cand_x;
      pend_y <= cand_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_mid || push_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_mid || (push_end && pend_v)) begin
      point_index <= pend_idx;
      kept_x <= pend_x;
      kept_y <= pend_y;
      run_end <= push_end;
      nothing_kept <= 1'b0;
      overflowed <= ovf;
    end else if (push_end) begin
      point_index <= '0;
      kept_x <= '0;
      kept_y <= '0;
      run_end <= 1'b1;
      nothing_kept <= 1'b1;
      overflowed <= ovf;
    end
  end

endmodule

// ----- rtl/radius_outlier_filter_2d_top.sv -----
// Radius outlier filter for a 2D cloud of up to MAX_POINTS points. Points are taken one beat per
// cycle while the filter is loading and land in a row of cells, one point to a cell. The beat
// marked last_point closes the cloud: every stored point then travels once around the ring of
// cells, so each cell counts the points closer than the radius to its own point; this sweep covers
// all MAX_POINTS cells whatever the cloud size. The cells then shift their points out toward cell
// zero, one per cycle unless the output stalls, and every point whose count reaches the least
// neighbor count is sent in input order; the final result carries run_end, and a cloud with no
// survivor gives one result with nothing_kept. Points beyond MAX_POINTS are dropped and every
// result of that cloud shows overflowed.
// Configuration writes are taken at any time and belong between clouds.
module radius_outlier_filter_2d_top #(
  parameter int MAX_POINTS = rof2d_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = rof2d_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rof2d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rof2d_pkg::RAD_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_BITS-1:0]        point_x,
  input  logic signed [COORD_BITS-1:0]        point_y,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rof2d_pkg::INDEX_W-1:0]       point_index,
  output logic signed [COORD_BITS-1:0]        kept_x,
  output logic signed [COORD_BITS-1:0]        kept_y,
  output logic                                run_end,
  output logic                                nothing_kept,
  output logic                                overflowed
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int KW = (CNT_W > rof2d_pkg::MINN_W) ? CNT_W : rof2d_pkg::MINN_W;

  rof2d_pkg::state_t state;
  rof2d_pkg::state_t state_next;
  logic [CNT_W-1:0] loaded;
  logic [CNT_W-1:0] step;
  logic ovf;
  logic [rof2d_pkg::MINN_W-1:0] least_count;
  logic [rof2d_pkg::RAD_W-1:0] radius_squared;
  logic in_beat;
  logic room;
  logic last_sweep;
  logic last_drain;
  logic scan_done;

  rof2d_pkg::cell_ctrl_t cctl;
  rof2d_pkg::emit_ctrl_t ectl;
  rof2d_pkg::emit_stat_t estat;

  logic signed [COORD_BITS-1:0] res_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] res_y [MAX_POINTS];
  logic [CNT_W-1:0] cnt [MAX_POINTS];
  logic signed [COORD_BITS-1:0] ring_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] ring_y [MAX_POINTS];
  logic ring_v [MAX_POINTS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      least_count <= '0;
      radius_squared <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rof2d_pkg::CFG_LEAST_COUNT: least_count <= cfg_data[rof2d_pkg::MINN_W-1:0];
        rof2d_pkg::CFG_RADIUS_SQUARED: radius_squared <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_ready = state == rof2d_pkg::ST_LOAD;
    in_beat = in_valid && in_ready;
    room = loaded != CNT_W'(MAX_POINTS);
    last_sweep = step == CNT_W'(MAX_POINTS - 1);
    last_drain = step == CNT_W'(rof2d_pkg::DRAIN_CYCLES - 1);
    scan_done = step == loaded;

    cctl.load = in_beat && room;
    cctl.prime = state == rof2d_pkg::ST_PRIME;
    cctl.eval = state == rof2d_pkg::ST_SWEEP;
    ectl.scan = (state == rof2d_pkg::ST_EMIT) && !scan_done;
    ectl.keep = KW'(cnt[0]) >= KW'(least_count);
    ectl.close = state == rof2d_pkg::ST_CLOSE;
    cctl.shift = estat.take;

    state_next = state;
    unique case (state)
      rof2d_pkg::ST_LOAD: if (in_beat && last_point) state_next = rof2d_pkg::ST_PRIME;
      rof2d_pkg::ST_PRIME: state_next = rof2d_pkg::ST_SWEEP;
      rof2d_pkg::ST_SWEEP: if (last_sweep) state_next = rof2d_pkg::ST_DRAIN;
      rof2d_pkg::ST_DRAIN: if (last_drain) state_next = rof2d_pkg::ST_EMIT;
      rof2d_pkg::ST_EMIT: if (scan_done) state_next = rof2d_pkg::ST_CLOSE;
      rof2d_pkg::ST_CLOSE: if (estat.done) state_next = rof2d_pkg::ST_LOAD;
      default: state_next = rof2d_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rof2d_pkg::ST_LOAD;
      loaded <= '0;
      ovf <= 1'b0;
      step <= '0;
    end else begin
      state <= state_next;
      if (in_beat) begin
        if (room) begin
          loaded <= loaded + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (estat.done) begin
        loaded <= '0;
        ovf <= 1'b0;
      end
      priority if (state != state_next) begin
        step <= '0;
      end else if (cctl.eval || state == rof2d_pkg::ST_DRAIN || estat.take) begin
        step <= step + CNT_W'(1);
      end
    end
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    localparam int PREV = (k == 0) ? MAX_POINTS - 1 : k - 1;
    logic signed [COORD_BITS-1:0] nx;
    logic signed [COORD_BITS-1:0] ny;
    logic [CNT_W-1:0] nc;

    if (k == MAX_POINTS - 1) begin : g_end
      assign nx = '0;
      assign ny = '0;
      assign nc = '0;
    end else begin : g_mid
      assign nx = res_x[k+1];
      assign ny = res_y[k+1];
      assign nc = cnt[k+1];
    end

    rof2d_cell #(
      .COORD_BITS(COORD_BITS),
      .CNT_W(CNT_W),
      .INDEX(k)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .ctrl(cctl),
      .loaded(loaded),
      .radius_squared(radius_squared),
      .load_x(point_x),
      .load_y(point_y),
      .next_x(nx),
      .next_y(ny),
      .next_cnt(nc),
      .ring_in_x(ring_x[PREV]),
      .ring_in_y(ring_y[PREV]),
      .ring_in_v(ring_v[PREV]),
      .res_x(res_x[k]),
      .res_y(res_y[k]),
      .count(cnt[k]),
      .ring_x(ring_x[k]),
      .ring_y(ring_y[k]),
      .ring_v(ring_v[k])
    );
  end

  rof2d_emit #(
    .COORD_BITS(COORD_BITS)
  ) u_emit (
    .clk(clk),
    .rst(rst),
    .ctl(ectl),
    .cand_index(rof2d_pkg::INDEX_W'(step)),
    .cand_x(res_x[0]),
    .cand_y(res_y[0]),
    .ovf(ovf),
    .stat(estat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .point_index(point_index),
    .kept_x(kept_x),
    .kept_y(kept_y),
    .run_end(run_end),
    .nothing_kept(nothing_kept),
    .overflowed(overflowed)
  );

endmodule

// ----- rtl/rof2d_checker.sv -----
module rof2d_checker #(
  parameter int COORD_BITS = rof2d_pkg::COORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          last_point,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rof2d_pkg::INDEX_W-1:0] point_index,
  input logic signed [COORD_BITS-1:0]  kept_x,
  input logic signed [COORD_BITS-1:0]  kept_y,
  input logic                          run_end,
  input logic                          nothing_kept,
  input logic                          overflowed
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_index) && $stable(kept_x)
      && $stable(kept_y) && $stable(run_end) && $stable(nothing_kept) && $stable(overflowed))
    else $error("result beat changed while stalled");

  // the empty result is the final one and carries no point
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && nothing_kept |-> run_end && point_index == '0 && kept_x == '0 && kept_y == '0)
    else $error("malformed empty result");

  // closing a cloud stops input until its final result has been issued
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_point |=> !in_ready)
    else $error("input taken right after the last point");

  a_no_input_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_end |-> !in_ready)
    else $error("input taken while a cloud is still being sent");

endmodule

bind radius_outlier_filter_2d_top rof2d_checker #(
  .COORD_BITS(COORD_BITS)
) u_rof2d_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .last_point(last_point),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .point_index(point_index),
  .kept_x(kept_x),
  .kept_y(kept_y),
  .run_end(run_end),
  .nothing_kept(nothing_kept),
  .overflowed(overflowed)
);
